// File: hw/rtl/dcsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcsv_pkg;

  // CORDIC x/y width: the 32-bit inputs, one bit for negation and room for the CORDIC gain
  localparam int CORDIC_XW = 35;

  // Angle and coefficient constants, in units of 1e-9
  localparam logic [63:0] PI_NANO     = 64'd3141592654;
  localparam logic [63:0] TWO_PI_NANO = 64'd6283185308;
  localparam logic [63:0] B1_NANO     = 64'd523598775;
  localparam logic [63:0] B2_NANO     = 64'd1570796327;
  localparam logic [63:0] B3_NANO     = 64'd2617993878;
  localparam logic [63:0] SIN60_NANO  = 64'd866667000;

  // atan(2^-i) in Q32
  localparam logic [31:0] ATAN_Q32 [0:30] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635, 32'd268086748,
    32'd134174063, 32'd67103403, 32'd33553749, 32'd16777131, 32'd8388597,
    32'd4194303, 32'd2097152, 32'd1048576, 32'd524288, 32'd262144, 32'd131072,
    32'd65536, 32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512,
    32'd256, 32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4
  };

  // Compensation amplitude and its 0.866667 product, both 31-bit unsigned
  typedef struct packed {
    logic [30:0] mag;
    logic [30:0] s60;
  } dcsv_comp_t;

  // Round a constant given in units of 1e-9 to a fixed-point value with frac fraction bits
  function automatic logic [63:0] nano_to_q(input logic [63:0] n, input int frac);
    return (n * (64'd1 << frac) + 64'd500000000) / 64'd1000000000;
  endfunction

  // CORDIC step angle rounded half up from Q32 to frac fraction bits
  function automatic logic [31:0] atan_q(input int i, input int frac);
    logic [63:0] t;
    int          sh;
    sh = 32 - frac;
    t  = {32'd0, ATAN_Q32[5'(i)]};
    return 32'((t + (64'd1 << (sh - 1))) >> sh);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/deadtime_comp_sector_vector.sv
`timescale 1ns / 1ps
`default_nettype none

// Dead-time compensation vector selector. Each transfer on the in_ channel carries the d and
// q stator currents and the rotor electrical angle (signed, FRAC_BITS fraction bits). The
// block finds the current-vector angle atan2(q, d) with a pipelined CORDIC of ATAN_ITERATIONS
// micro-rotations, adds the rotor angle, wraps the sum into (-pi, pi] by any number of whole
// turns and picks one of six 60-degree sectors centred on the phase axes. The out_ channel
// returns the wrapped angle (low 27 bits) and the alpha/beta compensation voltages, i.e. the
// configured amplitude times the sector's unit vector. Exactly one result per input, in order.
// The pipeline takes one transfer every clock while in_stall is low. It has W turn-removal
// stages, W = max(FRAC_BITS + 3, 26) - FRAC_BITS - 1. The whole pipeline advances together:
// in_stall is high exactly while a result sits on the out_ channel under out_stall. The
// amplitude register is written through cfg_ (always ready, reset 0); write it only while
// the block is idle.

module deadtime_comp_sector_vector #(
  parameter int FRAC_BITS       = 24,
  parameter int ATAN_ITERATIONS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_current_d,
  input  wire logic signed [31:0] in_current_q,
  input  wire logic signed [26:0] in_rotor_angle,

  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [26:0]      out_current_angle,
  output logic signed [31:0]      out_comp_alpha,
  output logic signed [31:0]      out_beta_comp,

  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [30:0]        cfg_comp_magnitude
);

  localparam int ZW = FRAC_BITS + 4;
  localparam int AW = ((FRAC_BITS + 3 > 26) ? FRAC_BITS + 3 : 26) + 2;

  localparam logic [FRAC_BITS-1:0] SIN60_Q =
    FRAC_BITS'(dcsv_pkg::nano_to_q(dcsv_pkg::SIN60_NANO, FRAC_BITS));

  // Pipeline enable: hold everything while the output transfer is blocked
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Configuration: amplitude register mag_r and its 0.866667 product s60_r, registered from mag_r
  logic [30:0]             mag_r;
  logic [30:0]             s60_r;
  logic [30+FRAC_BITS:0]   s60_prod;
  dcsv_pkg::dcsv_comp_t    comp;

  assign cfg_ready = 1'b1;
  assign s60_prod  = mag_r * SIN60_Q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= '0;
      s60_r <= '0;
    end else begin
      if (cfg_valid) begin
        mag_r <= cfg_comp_magnitude;
      end
      s60_r <= s60_prod[FRAC_BITS +: 31];
    end
  end

  assign comp.mag = mag_r;
  assign comp.s60 = s60_r;

  // CORDIC -> angle sum and wrap -> sector selection and output register
  logic                 cor_valid;
  logic signed [ZW-1:0] cor_z;
  logic signed [26:0]   cor_rot;
  logic                 wrap_valid;
  logic signed [AW-1:0] wrap_angle;

  dcsv_cordic #(
    .FRAC_BITS       (FRAC_BITS),
    .ATAN_ITERATIONS (ATAN_ITERATIONS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_d      (in_current_d),
    .in_q      (in_current_q),
    .in_rot    (in_rotor_angle),
    .out_valid (cor_valid),
    .out_z     (cor_z),
    .out_rot   (cor_rot)
  );

  dcsv_wrap #(
    .FRAC_BITS (FRAC_BITS)
  ) u_wrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cor_valid),
    .in_z      (cor_z),
    .in_rot    (cor_rot),
    .out_valid (wrap_valid),
    .out_angle (wrap_angle)
  );

  dcsv_sector #(
    .FRAC_BITS (FRAC_BITS)
  ) u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (wrap_valid),
    .in_angle  (wrap_angle),
    .comp      (comp),
    .out_valid (out_valid),
    .out_angle (out_current_angle),
    .out_alpha (out_comp_alpha),
    .out_beta  (out_beta_comp)
  );

endmodule

`default_nettype wire

// File: hw/rtl/dcsv_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module dcsv_cordic #(
  parameter int FRAC_BITS       = 24,
  parameter int ATAN_ITERATIONS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic signed [31:0]          in_d,
  input  wire logic signed [31:0]          in_q,
  input  wire logic signed [26:0]          in_rot,
  output logic                             out_valid,
  output logic signed [FRAC_BITS+3:0]      out_z,
  output logic signed [26:0]               out_rot
);

  localparam int XW = dcsv_pkg::CORDIC_XW;
  localparam int ZW = FRAC_BITS + 4;
  localparam int N  = ATAN_ITERATIONS;

  localparam logic signed [ZW-1:0] PI_Z = ZW'(dcsv_pkg::nano_to_q(dcsv_pkg::PI_NANO, FRAC_BITS));

  logic                 vld_r  [0:N];
  logic signed [XW-1:0] x_r    [0:N];
  logic signed [XW-1:0] y_r    [0:N];
  logic signed [ZW-1:0] z_r    [0:N];
  logic signed [26:0]   rot_r  [0:N];
  logic                 zero_r [0:N];

  // Pre-rotation: fold the left half-plane onto the right one
  logic signed [XW-1:0] d_ext, q_ext;
  logic signed [XW-1:0] x0_nxt, y0_nxt;
  logic signed [ZW-1:0] z0_nxt;

  assign d_ext = XW'(in_d);
  assign q_ext = XW'(in_q);

  always_comb begin
    if (in_d[31]) begin
      x0_nxt = -d_ext;
      y0_nxt = -q_ext;
      z0_nxt = in_q[31] ? -PI_Z : PI_Z;
    end else begin
      x0_nxt = d_ext;
      y0_nxt = q_ext;
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      z_r[0]    <= z0_nxt;
      rot_r[0]  <= in_rot;
      zero_r[0] <= (in_d == '0) && (in_q == '0);
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ATAN_I = ZW'(dcsv_pkg::atan_q(i, FRAC_BITS));

    logic signed [XW-1:0] xs, ys;
    logic signed [XW-1:0] x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_comb begin
      if (!y_r[i][XW-1]) begin
        x_nxt = x_r[i] + ys;
        y_nxt = y_r[i] - xs;
        z_nxt = z_r[i] + ATAN_I;
      end else begin
        x_nxt = x_r[i] - ys;
        y_nxt = y_r[i] + xs;
        z_nxt = z_r[i] - ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= x_nxt;
        y_r[i+1]    <= y_nxt;
        z_r[i+1]    <= z_nxt;
        rot_r[i+1]  <= rot_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  // Zero current vector has angle zero
  assign out_valid = vld_r[N];
  assign out_z     = zero_r[N] ? '0 : z_r[N];
  assign out_rot   = rot_r[N];

  // x starts non-negative and only grows; a sign flip means the datapath overflowed
  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[N] |-> !x_r[N][XW-1])
    else $error("cordic x went negative");

endmodule

`default_nettype wire

// File: hw/rtl/dcsv_wrap.sv
`timescale 1ns / 1ps
`default_nettype none

module dcsv_wrap #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst_n,
  input  wire logic                                             en,
  input  wire logic                                             in_valid,
  input  wire logic signed [FRAC_BITS+3:0]                      in_z,
  input  wire logic signed [26:0]                               in_rot,
  output logic                                                  out_valid,
  output logic signed [((FRAC_BITS + 3 > 26) ? FRAC_BITS + 3 : 26) + 1:0] out_angle
);

  localparam int AW = ((FRAC_BITS + 3 > 26) ? FRAC_BITS + 3 : 26) + 2;
  // Binary search steps for the number of whole turns to remove
  localparam int J  = AW - FRAC_BITS - 3;

  localparam logic signed [AW-1:0] PI_A  = AW'(dcsv_pkg::nano_to_q(dcsv_pkg::PI_NANO, FRAC_BITS));
  localparam logic signed [AW-1:0] TPI_A =
    AW'(dcsv_pkg::nano_to_q(dcsv_pkg::TWO_PI_NANO, FRAC_BITS));
  localparam logic signed [AW:0]   PI_E  = (AW+1)'(PI_A);

  logic                 vld_r [0:J];
  logic signed [AW-1:0] a_r   [0:J];
  logic                 up_r  [0:J];
  logic                 dn_r  [0:J];

  logic                 out_valid_r;
  logic signed [AW-1:0] angle_r;

  logic signed [AW-1:0] sum_nxt;
  logic signed [AW-1:0] angle_nxt;

  // Raw angle and direction of the wrap
  assign sum_nxt = AW'(in_z) + AW'(in_rot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]  <= sum_nxt;
      up_r[0] <= sum_nxt > PI_A;
      dn_r[0] <= sum_nxt <= -PI_A;
    end
  end

  // Remove 2^j turns while the angle stays outside the far bound
  for (genvar s = 0; s < J; s++) begin : g_step
    localparam int JS = J - 1 - s;
    localparam logic signed [AW:0] STEP =
      (AW+1)'(dcsv_pkg::nano_to_q(dcsv_pkg::TWO_PI_NANO, FRAC_BITS) << JS);

    logic signed [AW:0]   a_ext, cand_up, cand_dn;
    logic signed [AW-1:0] a_nxt;

    assign a_ext   = (AW+1)'(a_r[s]);
    assign cand_up = a_ext - STEP;
    assign cand_dn = a_ext + STEP;

    always_comb begin
      a_nxt = a_r[s];
      if (up_r[s] && (cand_up > PI_E)) begin
        a_nxt = cand_up[AW-1:0];
      end else if (dn_r[s] && (cand_dn <= -PI_E)) begin
        a_nxt = cand_dn[AW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[s+1]  <= a_nxt;
        up_r[s+1] <= up_r[s];
        dn_r[s+1] <= dn_r[s];
      end
    end
  end

  // One more turn lands the angle inside the half-open interval
  always_comb begin
    if (up_r[J]) begin
      angle_nxt = a_r[J] - TPI_A;
    end else if (dn_r[J]) begin
      angle_nxt = a_r[J] + TPI_A;
    end else begin
      angle_nxt = a_r[J];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[J];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = angle_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[J] |-> !(up_r[J] && dn_r[J]))
    else $error("wrap requested in both directions");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (angle_r <= PI_A + 1) && (angle_r >= -PI_A - 1))
    else $error("wrapped angle outside one turn");

endmodule

`default_nettype wire

// File: hw/rtl/dcsv_sector.sv
`timescale 1ns / 1ps
`default_nettype none

module dcsv_sector #(
  parameter int FRAC_BITS = 24
) (
  input  wire logic                                                  clk,
  input  wire logic                                                  rst_n,
  input  wire logic                                                  en,
  input  wire logic                                                  in_valid,
  input  wire logic signed [((FRAC_BITS + 3 > 26) ? FRAC_BITS + 3 : 26) + 1:0] in_angle,
  input  wire dcsv_pkg::dcsv_comp_t                                  comp,
  output logic                                                       out_valid,
  output logic signed [26:0]                                         out_angle,
  output logic signed [31:0]                                         out_alpha,
  output logic signed [31:0]                                         out_beta
);

  localparam int AW = ((FRAC_BITS + 3 > 26) ? FRAC_BITS + 3 : 26) + 2;

  localparam logic signed [AW-1:0] B1 = AW'(dcsv_pkg::nano_to_q(dcsv_pkg::B1_NANO, FRAC_BITS));
  localparam logic signed [AW-1:0] B2 = AW'(dcsv_pkg::nano_to_q(dcsv_pkg::B2_NANO, FRAC_BITS));
  localparam logic signed [AW-1:0] B3 = AW'(dcsv_pkg::nano_to_q(dcsv_pkg::B3_NANO, FRAC_BITS));

  logic                out_valid_r;
  logic signed [26:0]  angle_r;
  logic signed [31:0]  alpha_r, beta_r;

  logic signed [31:0]  mag, half, s60;
  logic signed [31:0]  alpha_nxt, beta_nxt;

  assign mag  = {1'b0, comp.mag};
  assign half = {2'b0, comp.mag[30:1]};
  assign s60  = {1'b0, comp.s60};

  always_comb begin
    if (in_angle <= B1 && in_angle > -B1) begin
      alpha_nxt = mag;
      beta_nxt  = '0;
    end else if (in_angle <= B2 && in_angle > B1) begin
      alpha_nxt = half;
      beta_nxt  = s60;
    end else if (in_angle <= B3 && in_angle > B2) begin
      alpha_nxt = -half;
      beta_nxt  = s60;
    end else if (in_angle > B3 || in_angle <= -B3) begin
      alpha_nxt = -mag;
      beta_nxt  = '0;
    end else if (in_angle <= -B2) begin
      alpha_nxt = -half;
      beta_nxt  = -s60;
    end else begin
      alpha_nxt = half;
      beta_nxt  = -s60;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= in_angle[26:0];
      alpha_r <= alpha_nxt;
      beta_r  <= beta_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = angle_r;
  assign out_alpha = alpha_r;
  assign out_beta  = beta_r;

  // A nonzero beta only comes with a half-amplitude alpha
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (beta_r != '0) |-> (alpha_r[31] == alpha_r[30]))
    else $error("full-amplitude alpha in an oblique sector");

endmodule

`default_nettype wire
